// ----- sv/vfc_pkg.sv -----
// ----------------------------------------------------------------------------
// vfc_pkg
// Field widths and face direction codes shared by the voxel face culling core.
// ----------------------------------------------------------------------------
`default_nettype none

package vfc_pkg;

  localparam int X_W    = 4;
  localparam int Y_W    = 7;
  localparam int Z_W    = 4;
  localparam int TYPE_W = 8;
  localparam int DIR_W  = 3;
  localparam int NUM_DIRS = 6;

  typedef logic [X_W-1:0]    pos_x_t;
  typedef logic [Y_W-1:0]    pos_y_t;
  typedef logic [Z_W-1:0]    pos_z_t;
  typedef logic [TYPE_W-1:0] block_type_t;
  typedef logic [DIR_W-1:0]  face_dir_t;
  typedef logic [NUM_DIRS-1:0] face_mask_t;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam face_dir_t DIR_PY = 3'd0;
  localparam face_dir_t DIR_NY = 3'd1;
  localparam face_dir_t DIR_PX = 3'd2;
  localparam face_dir_t DIR_NX = 3'd3;
  localparam face_dir_t DIR_PZ = 3'd4;
  localparam face_dir_t DIR_NZ = 3'd5;

  localparam block_type_t TYPE_AIR = '0;

endpackage

`default_nettype wire

// ----- sv/vfc_ram.sv -----
// ----------------------------------------------------------------------------
// vfc_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module vfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- sv/voxel_face_culling_core.sv -----
// ----------------------------------------------------------------------------
// voxel_face_culling_core
// Stores a voxel chunk and reports the exposed faces of a queried block.
// ----------------------------------------------------------------------------
// A write item stores its block type in the chunk memory. A query item reads
// the block and its six neighbours one after another from the single-port
// chunk memory, then sends one record per exposed face in the order +y, -y,
// +x, -x, +z, -z, 1 to 6 records in all, and takes no new item until the
// last of them is in the output register; output stalls prolong that. The
// seven memory reads all go through the one port. A record with face_valid
// low and last high answers an air block, a buried block or a query outside
// the chunk. The chunk memory is not cleared at reset, and a block must be
// written before it or its neighbours are queried.
`default_nettype none

module voxel_face_culling_core #(
  parameter int CHUNK_SIDE   = 16,
  parameter int CHUNK_HEIGHT = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 cmd,
  input  wire vfc_pkg::pos_x_t      pos_x,
  input  wire vfc_pkg::pos_y_t      pos_y,
  input  wire vfc_pkg::pos_z_t      pos_z,
  input  wire vfc_pkg::block_type_t block_type,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output vfc_pkg::pos_x_t           face_x,
  output vfc_pkg::pos_y_t           face_y,
  output vfc_pkg::pos_z_t           face_z,
  output vfc_pkg::face_dir_t        face_dir,
  output vfc_pkg::block_type_t      face_type,
  output logic                      face_valid,
  output logic                      last
);

  import vfc_pkg::*;

  localparam int DEPTH  = CHUNK_SIDE * CHUNK_SIDE * CHUNK_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CHK  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]  state;
  logic [2:0]  dir_cnt;
  pos_x_t      cur_x;
  pos_y_t      cur_y;
  pos_z_t      cur_z;
  block_type_t self_type;
  face_mask_t  mask;
  logic        prev_out;

  logic [X_W:0] nx;
  logic [Y_W:0] ny;
  logic [Z_W:0] nz;
  logic         n_under;
  logic         n_out;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  block_type_t       mem_rdata;

  logic in_fire;
  logic in_chunk;
  logic out_load;

  face_mask_t emit_bit;
  face_dir_t  emit_dir;
  logic       emit_found;

  // Linear address (x * height + y) * side + z; only used for positions inside.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [X_W:0] cx,
                                                  input logic [Y_W:0] cy,
                                                  input logic [Z_W:0] cz);
    logic [31:0] lin;
    lin = (32'(cx) * 32'(CHUNK_HEIGHT) + 32'(cy)) * 32'(CHUNK_SIDE) + 32'(cz);
    return lin[ADDR_W-1:0];
  endfunction

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_chunk = (32'(pos_x) < 32'(CHUNK_SIDE)) &&
                    (32'(pos_y) < 32'(CHUNK_HEIGHT)) &&
                    (32'(pos_z) < 32'(CHUNK_SIDE));

  // Neighbor of the current block in direction dir_cnt.
  always_comb begin
    nx      = {1'b0, cur_x};
    ny      = {1'b0, cur_y};
    nz      = {1'b0, cur_z};
    n_under = 1'b0;
    case (dir_cnt)
      DIR_PY: ny = {1'b0, cur_y} + 1'b1;
      DIR_NY: begin
        ny      = {1'b0, cur_y} - 1'b1;
        n_under = (cur_y == '0);
      end
      DIR_PX: nx = {1'b0, cur_x} + 1'b1;
      DIR_NX: begin
        nx      = {1'b0, cur_x} - 1'b1;
        n_under = (cur_x == '0);
      end
      DIR_PZ: nz = {1'b0, cur_z} + 1'b1;
      DIR_NZ: begin
        nz      = {1'b0, cur_z} - 1'b1;
        n_under = (cur_z == '0);
      end
      default: ;
    endcase
    n_out = n_under || (32'(nx) >= 32'(CHUNK_SIDE)) ||
            (32'(ny) >= 32'(CHUNK_HEIGHT)) || (32'(nz) >= 32'(CHUNK_SIDE));
  end

  always_comb begin
    if (state == S_IDLE) begin
      mem_addr = cell_addr({1'b0, pos_x}, {1'b0, pos_y}, {1'b0, pos_z});
    end else begin
      mem_addr = cell_addr(nx, ny, nz);
    end
    mem_we = in_fire && (cmd == CMD_WRITE) && in_chunk;
  end

  vfc_ram #(
    .WIDTH(TYPE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(block_type),
    .rdata(mem_rdata)
  );

  // Lowest remaining exposed face.
  always_comb begin
    emit_bit   = '0;
    emit_dir   = DIR_PY;
    emit_found = 1'b0;
    for (int i = 0; i < NUM_DIRS; i++) begin
      if (mask[i] && !emit_found) begin
        emit_found  = 1'b1;
        emit_bit[i] = 1'b1;
        emit_dir    = DIR_W'(i);
      end
    end
  end

  assign out_load = (state == S_EMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dir_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire && cmd == CMD_QUERY) begin
            cur_x   <= pos_x;
            cur_y   <= pos_y;
            cur_z   <= pos_z;
            dir_cnt <= '0;
            if (in_chunk) begin
              state <= S_READ;
            end else begin
              self_type <= TYPE_AIR;
              mask      <= '0;
              state     <= S_EMIT;
            end
          end
        end
        S_READ: begin
          // Data arriving now belongs to the read issued in the previous cycle.
          if (dir_cnt == DIR_PY) begin
            self_type <= mem_rdata;
          end else begin
            mask[dir_cnt - 3'd1] <= prev_out || (mem_rdata == TYPE_AIR);
          end
          prev_out <= n_out;
          if (dir_cnt == DIR_NZ) begin
            state <= S_CHK;
          end else begin
            dir_cnt <= dir_cnt + 3'd1;
          end
        end
        S_CHK: begin
          if (self_type == TYPE_AIR) begin
            mask <= '0;
          end else begin
            mask[NUM_DIRS-1] <= prev_out || (mem_rdata == TYPE_AIR);
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            face_x    <= cur_x;
            face_y    <= cur_y;
            face_z    <= cur_z;
            face_type <= self_type;
            if (emit_found) begin
              face_dir   <= emit_dir;
              face_valid <= 1'b1;
              last       <= ((mask & ~emit_bit) == '0);
              mask       <= mask & ~emit_bit;
              if ((mask & ~emit_bit) == '0) begin
                state <= S_IDLE;
              end
            end else begin
              face_dir   <= DIR_PY;
              face_valid <= 1'b0;
              last       <= 1'b1;
              state      <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Only the final record of a query may be a no-face record.
  a_nofirst_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> face_valid)
    else $error("non-final record without a face");

  a_noface_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !face_valid |-> last && face_dir == DIR_PY)
    else $error("malformed no-face record");

  // Faces of one query leave in strictly increasing direction order.
  a_dir_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> !out_valid || face_dir > $past(face_dir))
    else $error("face records out of order");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !mem_we)
    else $error("chunk write while a query is in progress");

endmodule

`default_nettype wire

// ----- verif/voxel_face_culling_core_test.sv -----
// ----------------------------------------------------------------------------
// voxel_face_culling_core_test
// Self-checking testbench for the voxel face culling core.
// ----------------------------------------------------------------------------
// Write and query items go to the core through its input handshake. A small
// scoreboard keeps its own copy of the chunk and works out the face records
// that each query should return. Every record that the core sends is checked
// against the oldest record still awaited. Queries only touch cells whose
// whole neighborhood has been written, since the chunk memory is not cleared.
// Both handshakes idle at random, and the output side holds off once for a
// long stretch so that the core backs up into its input.
`default_nettype none

module voxel_face_culling_core_test;
  import vfc_pkg::*;

  localparam int SIDE   = 16;
  localparam int HEIGHT = 128;
  localparam int ITEM_GOAL   = 260;
  localparam int QUERY_GOAL  = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SQUEEZE_CYCLES = 300;

  typedef struct packed {
    pos_x_t      x;
    pos_y_t      y;
    pos_z_t      z;
    face_dir_t   dir;
    block_type_t kind;
    logic        open;
    logic        last;
  } face_rec_t;

  // Keeps a copy of the chunk and the face records that are still owed.
  class exposed_faces #(int SIDE = 16, int HEIGHT = 128);
    block_type_t voxels [SIDE*SIDE*HEIGHT];
    bit          written [SIDE*SIDE*HEIGHT];
    face_rec_t   awaited [$];
    int errors, writes, queries, records, open_faces;

    function int cell_of(int x, int y, int z);
      return (x * HEIGHT + y) * SIDE + z;
    endfunction

    function bit is_written(int x, int y, int z);
      return written[cell_of(x, y, z)];
    endfunction

    // Returns 1 when the neighbor on side d lies inside the chunk.
    function bit neighbour(int x, int y, int z, face_dir_t d,
                           output int nx, output int ny, output int nz);
      nx = x;
      ny = y;
      nz = z;
      case (d)
        DIR_PY: ny = y + 1;
        DIR_NY: ny = y - 1;
        DIR_PX: nx = x + 1;
        DIR_NX: nx = x - 1;
        DIR_PZ: nz = z + 1;
        default: nz = z - 1;
      endcase
      return nx >= 0 && nx < SIDE && ny >= 0 && ny < HEIGHT && nz >= 0 && nz < SIDE;
    endfunction

    function void take_item(logic c, pos_x_t x, pos_y_t y, pos_z_t z, block_type_t t);
      face_rec_t   found [$];
      face_rec_t   rec;
      block_type_t self;
      face_dir_t   d;
      int          nx, ny, nz;
      if (c == CMD_WRITE) begin
        voxels[cell_of(x, y, z)] = t;
        written[cell_of(x, y, z)] = 1'b1;
        writes++;
        return;
      end
      queries++;
      self = voxels[cell_of(x, y, z)];
      rec = '{x: x, y: y, z: z, dir: DIR_PY, kind: self, open: 1'b1, last: 1'b0};
      if (self != TYPE_AIR) begin
        for (int i = 0; i < NUM_DIRS; i++) begin
          d = face_dir_t'(i);
          // A neighbor beyond the chunk border counts as air.
          if (!neighbour(x, y, z, d, nx, ny, nz) ||
              voxels[cell_of(nx, ny, nz)] == TYPE_AIR) begin
            rec.dir = d;
            found.push_back(rec);
          end
        end
      end
      if (found.size() == 0) begin
        rec.dir = DIR_PY;
        rec.open = 1'b0;
        found.push_back(rec);
      end
      found[found.size()-1].last = 1'b1;
      foreach (found[i]) awaited.push_back(found[i]);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_record(face_rec_t got);
      face_rec_t want;
      if (awaited.size() == 0) begin
        $error("face record with none awaited: x=%0d y=%0d z=%0d dir=%0d",
               got.x, got.y, got.z, got.dir);
        errors++;
        return;
      end
      want = awaited.pop_front();
      records++;
      if (want.open) open_faces++;
      compare("face_x", want.x, got.x);
      compare("face_y", want.y, got.y);
      compare("face_z", want.z, got.z);
      compare("face_dir", want.dir, got.dir);
      compare("face_type", want.kind, got.kind);
      compare("face_valid", want.open, got.open);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        cmd;
  pos_x_t      pos_x;
  pos_y_t      pos_y;
  pos_z_t      pos_z;
  block_type_t block_type;
  logic        out_valid;
  logic        out_ready;
  pos_x_t      face_x;
  pos_y_t      face_y;
  pos_z_t      face_z;
  face_dir_t   face_dir;
  block_type_t face_type;
  logic        face_valid;
  logic        last;

  exposed_faces #(SIDE, HEIGHT) faces;
  int items_sent;
  bit no_gaps;
  int home_x, home_y, home_z;

  voxel_face_culling_core #(
    .CHUNK_SIDE   (SIDE),
    .CHUNK_HEIGHT (HEIGHT)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .block_type (block_type),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .face_x     (face_x),
    .face_y     (face_y),
    .face_z     (face_z),
    .face_dir   (face_dir),
    .face_type  (face_type),
    .face_valid (face_valid),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic block_type_t rand_type();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return TYPE_AIR;
    if (r < 48) return 8'hFF;
    return block_type_t'($urandom_range(1, 254));
  endfunction

  function automatic int pick_coord(int hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 0;
    if (r < 24) return hi;
    return $urandom_range(0, hi);
  endfunction

  function automatic int near(int centre, int hi);
    int v;
    v = centre + $urandom_range(0, 4) - 2;
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic send_item(logic c, int x, int y, int z, block_type_t t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    cmd        <= c;
    pos_x      <= pos_x_t'(x);
    pos_y      <= pos_y_t'(y);
    pos_z      <= pos_z_t'(z);
    block_type <= t;
    do @(posedge clk); while (!in_ready);
    faces.take_item(c, pos_x_t'(x), pos_y_t'(y), pos_z_t'(z), t);
    items_sent++;
  endtask

  task automatic put(int x, int y, int z, block_type_t t);
    send_item(CMD_WRITE, x, y, z, t);
  endtask

  task automatic ask(int x, int y, int z);
    send_item(CMD_QUERY, x, y, z, block_type_t'($urandom_range(0, 255)));
  endtask

  // Writes every cell around (x, y, z) that has not been written yet, so the
  // query that follows never reads an undefined cell.
  task automatic fill_around(int x, int y, int z);
    int nx, ny, nz;
    if (!faces.is_written(x, y, z)) put(x, y, z, rand_type());
    for (int i = 0; i < NUM_DIRS; i++) begin
      if (faces.neighbour(x, y, z, face_dir_t'(i), nx, ny, nz) &&
          !faces.is_written(nx, ny, nz))
        put(nx, ny, nz, rand_type());
    end
  endtask

  // Output side: checks records and stalls at random, with one long hold-off.
  initial begin
    int hold, run, seen;
    bit squeezed;
    hold = 0;
    run = 0;
    seen = 0;
    squeezed = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        faces.check_record('{x: face_x, y: face_y, z: face_z, dir: face_dir,
                             kind: face_type, open: face_valid, last: last});
        seen++;
      end
      @(negedge clk);
      if (!squeezed && seen >= 40) begin
        squeezed = 1'b1;
        hold = SQUEEZE_CYCLES;
      end
      if (hold == 0 && run == 0) begin
        hold = pick_gap();
        run = $urandom_range(1, 10);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        run--;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles", CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int x, y, z, step;
    faces = new();
    items_sent = 0;
    no_gaps = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_WRITE;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    block_type = TYPE_AIR;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Corner at the origin with air around it: all six sides are exposed.
    put(0, 0, 0, 8'hFF);
    put(1, 0, 0, TYPE_AIR);
    put(0, 1, 0, TYPE_AIR);
    put(0, 0, 1, TYPE_AIR);
    ask(0, 0, 0);
    // Far corner with solid neighbors: only the three border sides show.
    put(15, 127, 15, 8'h01);
    put(14, 127, 15, 8'hA5);
    put(15, 126, 15, 8'h5A);
    put(15, 127, 14, 8'h80);
    ask(15, 127, 15);
    // Buried block, then one opening above it, then the block turned to air.
    put(7, 64, 8, 8'h3C);
    put(7, 65, 8, 8'h01);
    put(7, 63, 8, 8'h02);
    put(8, 64, 8, 8'h04);
    put(6, 64, 8, 8'h08);
    put(7, 64, 9, 8'h10);
    put(7, 64, 7, 8'h20);
    ask(7, 64, 8);
    put(7, 65, 8, TYPE_AIR);
    ask(7, 64, 8);
    put(7, 64, 8, TYPE_AIR);
    ask(7, 64, 8);

    // Mostly write-neighborhood-then-query sequences around a wandering home
    // position, mixed with stray writes that overwrite cells.
    step = 0;
    while (items_sent < ITEM_GOAL || faces.queries < QUERY_GOAL) begin
      if (step % 30 == 0) begin
        home_x = pick_coord(SIDE - 1);
        home_y = pick_coord(HEIGHT - 1);
        home_z = pick_coord(SIDE - 1);
      end
      no_gaps = (items_sent >= 140 && items_sent < 180);
      if ($urandom_range(0, 99) < 70) begin
        x = near(home_x, SIDE - 1);
        y = near(home_y, HEIGHT - 1);
        z = near(home_z, SIDE - 1);
      end else begin
        x = pick_coord(SIDE - 1);
        y = pick_coord(HEIGHT - 1);
        z = pick_coord(SIDE - 1);
      end
      if ($urandom_range(0, 99) < 25) begin
        put(x, y, z, rand_type());
      end else begin
        fill_around(x, y, z);
        ask(x, y, z);
      end
      step++;
    end
    no_gaps = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (faces.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Run covered %0d writes and %0d queries, which gave %0d face records",
             faces.writes, faces.queries, faces.records);
    $display("(%0d exposed faces), with random stalls and one long output hold-off.",
             faces.open_faces);
    if (faces.errors == 0 && faces.awaited.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/vfc_pkg.sv
sv/vfc_ram.sv
sv/voxel_face_culling_core.sv
verif/voxel_face_culling_core_test.sv
